// File: rtl/core/lst_pkg.sv
// ----------------------------------------------------------------------------
// Lane segment tracker package
// Shared widths, register indexes, reset values and channel payload types.
// ----------------------------------------------------------------------------
package lst_pkg;

   localparam int COORD_BITS     = 11;
   localparam int SLOPE_BITS     = 12;
   localparam int Q10_BITS       = 10;
   localparam int COUNT_BITS     = 16;
   localparam int FRAME_DECIMATION = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIDDLE_COLUMN  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOTTOM_ROW     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOPE_LOW_Q10  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOPE_HIGH_Q10 = 2'd3;

   localparam logic [COORD_BITS-1:0] MIDDLE_COLUMN_RESET  = 11'd625;
   localparam logic [COORD_BITS-1:0] BOTTOM_ROW_RESET     = 11'd510;
   localparam logic [SLOPE_BITS-1:0] SLOPE_LOW_RESET      = 12'd591;
   localparam logic [SLOPE_BITS-1:0] SLOPE_HIGH_RESET     = 12'd1220;

   localparam logic [COORD_BITS-1:0] LEFT_TOP_X_RESET     = 11'd537;
   localparam logic [COORD_BITS-1:0] LEFT_TOP_Y_RESET     = 11'd430;
   localparam logic [COORD_BITS-1:0] RIGHT_TOP_X_RESET    = 11'd765;
   localparam logic [COORD_BITS-1:0] RIGHT_TOP_Y_RESET    = 11'd430;
   localparam logic [COORD_BITS-1:0] LEFT_BOTTOM_X_RESET  = 11'd415;
   localparam logic [COORD_BITS-1:0] RIGHT_BOTTOM_X_RESET = 11'd870;

   typedef struct packed {
      logic                  action;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } lst_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] left_top_x;
      logic [COORD_BITS-1:0] left_top_y;
      logic [COORD_BITS-1:0] right_top_x;
      logic [COORD_BITS-1:0] right_top_y;
      logic [COORD_BITS-1:0] left_bottom_x;
      logic [COORD_BITS-1:0] left_bottom_y;
      logic [COORD_BITS-1:0] right_bottom_x;
      logic [COORD_BITS-1:0] right_bottom_y;
   } lst_rsp_type;

endpackage

// File: rtl/core/lst_slope.sv
// ----------------------------------------------------------------------------
// Lane segment tracker slope window check
// Bit-serial multiply of dx by both Q10 bounds, then a strict window compare
// against dy scaled by 1024.
// ----------------------------------------------------------------------------
module lst_slope #(
   parameter int COORD_BITS = lst_pkg::COORD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [COORD_BITS-1:0]          dx,
   input  logic [COORD_BITS-1:0]          dy,
   input  logic [lst_pkg::SLOPE_BITS-1:0] slope_low,
   input  logic [lst_pkg::SLOPE_BITS-1:0] slope_high,
   output logic                           done,
   output logic                           pass
);

   localparam int SB       = lst_pkg::SLOPE_BITS;
   localparam int PW       = SB + COORD_BITS;
   localparam int CNT_BITS = $clog2(COORD_BITS + 1);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(COORD_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  cmp_ff, cmp_in;
   logic                  done_ff, done_in;
   logic                  pass_ff, pass_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] dx_sr_ff, dx_sr_in;
   logic [COORD_BITS-1:0] dy_ff, dy_in;
   logic [SB-1:0]         lo_hi_ff, lo_hi_in;
   logic [COORD_BITS-1:0] lo_lo_ff, lo_lo_in;
   logic [SB-1:0]         hi_hi_ff, hi_hi_in;
   logic [COORD_BITS-1:0] hi_lo_ff, hi_lo_in;

   logic [SB:0]           sum_lo;
   logic [SB:0]           sum_hi;
   logic [PW-1:0]         scaled;
   logic [PW-1:0]         prod_lo;
   logic [PW-1:0]         prod_hi;

   always_comb begin
      sum_lo  = {1'b0, lo_hi_ff} + (dx_sr_ff[0] ? {1'b0, slope_low}  : '0);
      sum_hi  = {1'b0, hi_hi_ff} + (dx_sr_ff[0] ? {1'b0, slope_high} : '0);
      scaled  = PW'({dy_ff, {lst_pkg::Q10_BITS{1'b0}}});
      prod_lo = {lo_hi_ff, lo_lo_ff};
      prod_hi = {hi_hi_ff, hi_lo_ff};

      busy_in  = busy_ff;
      cmp_in   = 1'b0;
      done_in  = 1'b0;
      pass_in  = pass_ff;
      cnt_in   = cnt_ff;
      dx_sr_in = dx_sr_ff;
      dy_in    = dy_ff;
      lo_hi_in = lo_hi_ff;
      lo_lo_in = lo_lo_ff;
      hi_hi_in = hi_hi_ff;
      hi_lo_in = hi_lo_ff;

      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         dx_sr_in = dx;
         dy_in    = dy;
         lo_hi_in = '0;
         lo_lo_in = '0;
         hi_hi_in = '0;
         hi_lo_in = '0;
      end else if (busy_ff) begin
         // shift the low product bit out of each accumulator
         lo_hi_in = sum_lo[SB:1];
         lo_lo_in = {sum_lo[0], lo_lo_ff[COORD_BITS-1:1]};
         hi_hi_in = sum_hi[SB:1];
         hi_lo_in = {sum_hi[0], hi_lo_ff[COORD_BITS-1:1]};
         dx_sr_in = {1'b0, dx_sr_ff[COORD_BITS-1:1]};
         cnt_in   = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            cmp_in  = 1'b1;
         end
      end

      if (cmp_ff) begin
         pass_in = (scaled > prod_lo) && (scaled < prod_hi);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cmp_ff  <= 1'b0;
         done_ff <= 1'b0;
         pass_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cmp_ff  <= cmp_in;
         done_ff <= done_in;
         pass_ff <= pass_in;
         cnt_ff  <= cnt_in;
      end
      dx_sr_ff <= dx_sr_in;
      dy_ff    <= dy_in;
      lo_hi_ff <= lo_hi_in;
      lo_lo_ff <= lo_lo_in;
      hi_hi_ff <= hi_hi_in;
      hi_lo_ff <= hi_lo_in;
   end

   assign done = done_ff;
   assign pass = pass_ff;

endmodule

// File: rtl/core/lst_avg.sv
// ----------------------------------------------------------------------------
// Lane segment tracker running average unit
// Computes floor((held * count + fresh) / (count + 1)) with a bit-serial
// shift-add multiply followed by a restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module lst_avg #(
   parameter int COORD_BITS = lst_pkg::COORD_BITS,
   parameter int COUNT_BITS = lst_pkg::COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] held,
   input  logic [COORD_BITS-1:0] fresh,
   input  logic [COUNT_BITS-1:0] count,
   output logic                  done,
   output logic [COORD_BITS-1:0] result
);

   localparam int HW       = (COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS;
   localparam int CNT_BITS = $clog2(COORD_BITS + 1);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(COORD_BITS - 1);

   localparam logic [1:0] AV_IDLE = 2'd0;
   localparam logic [1:0] AV_MUL  = 2'd1;
   localparam logic [1:0] AV_DIV  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] held_sr_ff, held_sr_in;
   logic [COUNT_BITS-1:0] mcand_ff, mcand_in;
   logic [COUNT_BITS:0]   divisor_ff, divisor_in;
   logic [HW-1:0]         hi_ff, hi_in;
   logic [COORD_BITS-1:0] lo_ff, lo_in;

   logic [HW:0]           sum;
   logic [HW:0]           rem2;
   logic [HW:0]           divisor_ext;
   logic [HW:0]           diff;
   logic                  ge;

   always_comb begin
      sum         = {1'b0, hi_ff} + (held_sr_ff[0] ? (HW+1)'(mcand_ff) : '0);
      rem2        = {hi_ff, lo_ff[COORD_BITS-1]};
      divisor_ext = (HW+1)'(divisor_ff);
      ge          = rem2 >= divisor_ext;
      diff        = rem2 - divisor_ext;

      state_in   = state_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      held_sr_in = held_sr_ff;
      mcand_in   = mcand_ff;
      divisor_in = divisor_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;

      unique case (state_ff)
         AV_IDLE: begin
            if (start) begin
               // seed the accumulator with fresh so the product comes out as held*count+fresh
               state_in   = AV_MUL;
               cnt_in     = '0;
               held_sr_in = held;
               mcand_in   = count;
               divisor_in = {1'b0, count} + (COUNT_BITS+1)'(1);
               hi_in      = HW'(fresh);
               lo_in      = '0;
            end
         end
         AV_MUL: begin
            hi_in      = sum[HW:1];
            lo_in      = {sum[0], lo_ff[COORD_BITS-1:1]};
            held_sr_in = {1'b0, held_sr_ff[COORD_BITS-1:1]};
            cnt_in     = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = AV_DIV;
               cnt_in   = '0;
            end
         end
         AV_DIV: begin
            // quotient stays below 2^COORD_BITS, so the high half starts below the divisor
            hi_in  = ge ? diff[HW-1:0] : rem2[HW-1:0];
            lo_in  = {lo_ff[COORD_BITS-2:0], ge};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = AV_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = AV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AV_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      held_sr_ff <= held_sr_in;
      mcand_ff   <= mcand_in;
      divisor_ff <= divisor_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
   end

   assign done   = done_ff;
   assign result = lo_ff;

endmodule

// File: rtl/core/lane_segment_tracker.sv
// ----------------------------------------------------------------------------
// Lane segment tracker
// Keeps a four-corner lane polygon from Hough line segments and frame markers.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per frame marker or line segment; the block
//   raises req_stall while it works on a transaction. rsp_* returns all eight
//   polygon corners for every transaction; hold rsp_stall high to back-pressure.
//   csr_* writes the middle column, bottom row and the two Q10 slope bounds;
//   csr_ready is always high, write only while no transaction is in flight.
// Flow:
//   Markers and ignored segments go straight to the emit state. A used
//   segment adds a bit-serial slope check and zero to two running averages,
//   run one after another on one shared multiply/divide unit. The emit state
//   loads the result into the output register once that register is free.
//   The next transaction is taken once the result sits in the output
//   register, even while the receiver still stalls it.
// Reset:
//   Synchronous; restores the default registers, the default polygon, clears
//   the averaging counts and waits for the FRAME_DECIMATION-th frame marker.
// ----------------------------------------------------------------------------
module lane_segment_tracker #(
   parameter int COUNT_BITS       = lst_pkg::COUNT_BITS,
   parameter int FRAME_DECIMATION = lst_pkg::FRAME_DECIMATION
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lst_pkg::lst_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lst_pkg::lst_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lst_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lst_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int CB         = lst_pkg::COORD_BITS;
   localparam int SB         = lst_pkg::SLOPE_BITS;
   localparam int PHASE_BITS = $clog2(FRAME_DECIMATION + 1);
   localparam logic [PHASE_BITS-1:0] PHASE_LIMIT = PHASE_BITS'(FRAME_DECIMATION);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SLOPE    = 3'd1;
   localparam logic [2:0] ST_AVG_GO   = 3'd2;
   localparam logic [2:0] ST_AVG_WAIT = 3'd3;
   localparam logic [2:0] ST_EMIT     = 3'd4;

   // averaging slots
   localparam logic [1:0] SLOT_RIGHT_TOP_Y    = 2'd0;
   localparam logic [1:0] SLOT_LEFT_BOTTOM_X  = 2'd1;
   localparam logic [1:0] SLOT_RIGHT_BOTTOM_X = 2'd2;

   logic [2:0]            state_ff, state_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  active_ff, active_in;

   logic [CB-1:0]         middle_ff, middle_in;
   logic [CB-1:0]         bottom_ff, bottom_in;
   logic [SB-1:0]         slope_low_ff, slope_low_in;
   logic [SB-1:0]         slope_high_ff, slope_high_in;

   logic [CB-1:0]         ltx_ff, ltx_in;
   logic [CB-1:0]         lty_ff, lty_in;
   logic [CB-1:0]         rtx_ff, rtx_in;
   logic [CB-1:0]         rty_ff, rty_in;
   logic [CB-1:0]         lbx_ff, lbx_in;
   logic [CB-1:0]         rbx_ff, rbx_in;
   logic [COUNT_BITS-1:0] counts_ff [3];
   logic [COUNT_BITS-1:0] counts_in [3];

   logic [CB-1:0]         x1_ff, x1_in;
   logic [CB-1:0]         y1_ff, y1_in;
   logic [CB-1:0]         x2_ff, x2_in;
   logic [CB-1:0]         y2_ff, y2_in;

   logic                  job0_en_ff, job0_en_in;
   logic [1:0]            job0_slot_ff, job0_slot_in;
   logic [CB-1:0]         job0_fresh_ff, job0_fresh_in;
   logic                  job1_en_ff, job1_en_in;
   logic [1:0]            job1_slot_ff, job1_slot_in;
   logic [CB-1:0]         job1_fresh_ff, job1_fresh_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   lst_pkg::lst_rsp_type  rsp_data_ff, rsp_data_in;

   logic [PHASE_BITS-1:0] phase_next;
   logic                  seg_ordered;
   logic [CB-1:0]         seg_dx;
   logic [CB-1:0]         seg_dy;
   logic                  slope_start;
   logic                  slope_done;
   logic                  slope_pass;
   logic                  avg_start;
   logic                  avg_done;
   logic [CB-1:0]         avg_result;
   logic [CB-1:0]         avg_held;
   logic [COUNT_BITS-1:0] avg_count;
   logic [COUNT_BITS-1:0] avg_count_next;
   logic                  side_right;
   logic                  side_left;

   lst_slope #(
      .COORD_BITS (CB)
   ) u_slope (
      .clock      (clock),
      .reset      (reset),
      .start      (slope_start),
      .dx         (seg_dx),
      .dy         (seg_dy),
      .slope_low  (slope_low_ff),
      .slope_high (slope_high_ff),
      .done       (slope_done),
      .pass       (slope_pass)
   );

   lst_avg #(
      .COORD_BITS (CB),
      .COUNT_BITS (COUNT_BITS)
   ) u_avg (
      .clock  (clock),
      .reset  (reset),
      .start  (avg_start),
      .held   (avg_held),
      .fresh  (job0_fresh_ff),
      .count  (avg_count),
      .done   (avg_done),
      .result (avg_result)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // held value and count of the slot at the head of the job list
   always_comb begin
      unique case (job0_slot_ff)
         SLOT_RIGHT_TOP_Y: begin
            avg_held  = rty_ff;
            avg_count = counts_ff[0];
         end
         SLOT_LEFT_BOTTOM_X: begin
            avg_held  = lbx_ff;
            avg_count = counts_ff[1];
         end
         SLOT_RIGHT_BOTTOM_X: begin
            avg_held  = rbx_ff;
            avg_count = counts_ff[2];
         end
         default: begin
            avg_held  = rty_ff;
            avg_count = counts_ff[0];
         end
      endcase
      avg_count_next = (avg_count != {COUNT_BITS{1'b1}}) ?
                       avg_count + COUNT_BITS'(1) : avg_count;
   end

   always_comb begin
      phase_next  = phase_ff + PHASE_BITS'(1);
      seg_ordered = req_data.start_x < req_data.end_x;
      seg_dx      = req_data.end_x - req_data.start_x;
      seg_dy      = (req_data.start_y > req_data.end_y) ?
                    req_data.start_y - req_data.end_y :
                    req_data.end_y - req_data.start_y;
      side_right  = (x1_ff > middle_ff) && (x2_ff > middle_ff);
      side_left   = (x1_ff < middle_ff) && (x2_ff < middle_ff);

      state_in      = state_ff;
      phase_in      = phase_ff;
      active_in     = active_ff;
      middle_in     = middle_ff;
      bottom_in     = bottom_ff;
      slope_low_in  = slope_low_ff;
      slope_high_in = slope_high_ff;
      ltx_in        = ltx_ff;
      lty_in        = lty_ff;
      rtx_in        = rtx_ff;
      rty_in        = rty_ff;
      lbx_in        = lbx_ff;
      rbx_in        = rbx_ff;
      counts_in     = counts_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      x2_in         = x2_ff;
      y2_in         = y2_ff;
      job0_en_in    = job0_en_ff;
      job0_slot_in  = job0_slot_ff;
      job0_fresh_in = job0_fresh_ff;
      job1_en_in    = job1_en_ff;
      job1_slot_in  = job1_slot_ff;
      job1_fresh_in = job1_fresh_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      slope_start   = 1'b0;
      avg_start     = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            lst_pkg::CSR_MIDDLE_COLUMN:  middle_in     = csr_data[CB-1:0];
            lst_pkg::CSR_BOTTOM_ROW:     bottom_in     = csr_data[CB-1:0];
            lst_pkg::CSR_SLOPE_LOW_Q10:  slope_low_in  = csr_data[SB-1:0];
            lst_pkg::CSR_SLOPE_HIGH_Q10: slope_high_in = csr_data[SB-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x1_in = req_data.start_x;
               y1_in = req_data.start_y;
               x2_in = req_data.end_x;
               y2_in = req_data.end_y;
               if (!req_data.action) begin
                  if (phase_next >= PHASE_LIMIT) begin
                     phase_in  = '0;
                     active_in = 1'b1;
                  end else begin
                     phase_in  = phase_next;
                     active_in = 1'b0;
                  end
                  state_in = ST_EMIT;
               end else if (active_ff && seg_ordered) begin
                  slope_start = 1'b1;
                  state_in    = ST_SLOPE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SLOPE: begin
            if (slope_done) begin
               job0_en_in = 1'b0;
               job1_en_in = 1'b0;
               if (slope_pass && side_right) begin
                  if (y1_ff > y2_ff) begin
                     rtx_in        = x2_ff;
                     rty_in        = y2_ff;
                     job0_en_in    = bottom_ff < y1_ff;
                     job0_slot_in  = SLOT_RIGHT_BOTTOM_X;
                     job0_fresh_in = x1_ff;
                  end else begin
                     // top y averages first, then the bottom x if the end is below
                     rtx_in        = x1_ff;
                     job0_en_in    = 1'b1;
                     job0_slot_in  = SLOT_RIGHT_TOP_Y;
                     job0_fresh_in = y1_ff;
                     job1_en_in    = bottom_ff < y2_ff;
                     job1_slot_in  = SLOT_RIGHT_BOTTOM_X;
                     job1_fresh_in = x2_ff;
                  end
               end else if (slope_pass && side_left) begin
                  if (y1_ff < y2_ff) begin
                     ltx_in        = x1_ff;
                     lty_in        = y1_ff;
                     job0_en_in    = bottom_ff < y2_ff;
                     job0_slot_in  = SLOT_LEFT_BOTTOM_X;
                     job0_fresh_in = x2_ff;
                  end else begin
                     ltx_in        = x2_ff;
                     lty_in        = y2_ff;
                     job0_en_in    = bottom_ff < y1_ff;
                     job0_slot_in  = SLOT_LEFT_BOTTOM_X;
                     job0_fresh_in = x1_ff;
                  end
               end
               state_in = job0_en_in ? ST_AVG_GO : ST_EMIT;
            end
         end
         ST_AVG_GO: begin
            avg_start = 1'b1;
            state_in  = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (avg_done) begin
               unique case (job0_slot_ff)
                  SLOT_RIGHT_TOP_Y: begin
                     rty_in       = avg_result;
                     counts_in[0] = avg_count_next;
                  end
                  SLOT_LEFT_BOTTOM_X: begin
                     lbx_in       = avg_result;
                     counts_in[1] = avg_count_next;
                  end
                  SLOT_RIGHT_BOTTOM_X: begin
                     rbx_in       = avg_result;
                     counts_in[2] = avg_count_next;
                  end
                  default: begin
                     rty_in = rty_ff;
                  end
               endcase
               // advance the job list
               if (job1_en_ff) begin
                  job0_en_in    = 1'b1;
                  job0_slot_in  = job1_slot_ff;
                  job0_fresh_in = job1_fresh_ff;
                  job1_en_in    = 1'b0;
                  state_in      = ST_AVG_GO;
               end else begin
                  job0_en_in = 1'b0;
                  state_in   = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.left_top_x      = ltx_ff;
               rsp_data_in.left_top_y      = lty_ff;
               rsp_data_in.right_top_x     = rtx_ff;
               rsp_data_in.right_top_y     = rty_ff;
               rsp_data_in.left_bottom_x   = lbx_ff;
               rsp_data_in.left_bottom_y   = bottom_ff;
               rsp_data_in.right_bottom_x  = rbx_ff;
               rsp_data_in.right_bottom_y  = bottom_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= '0;
         active_ff     <= 1'b0;
         middle_ff     <= lst_pkg::MIDDLE_COLUMN_RESET;
         bottom_ff     <= lst_pkg::BOTTOM_ROW_RESET;
         slope_low_ff  <= lst_pkg::SLOPE_LOW_RESET;
         slope_high_ff <= lst_pkg::SLOPE_HIGH_RESET;
         ltx_ff        <= lst_pkg::LEFT_TOP_X_RESET;
         lty_ff        <= lst_pkg::LEFT_TOP_Y_RESET;
         rtx_ff        <= lst_pkg::RIGHT_TOP_X_RESET;
         rty_ff        <= lst_pkg::RIGHT_TOP_Y_RESET;
         lbx_ff        <= lst_pkg::LEFT_BOTTOM_X_RESET;
         rbx_ff        <= lst_pkg::RIGHT_BOTTOM_X_RESET;
         counts_ff[0]  <= '0;
         counts_ff[1]  <= '0;
         counts_ff[2]  <= '0;
         job0_en_ff    <= 1'b0;
         job1_en_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         active_ff     <= active_in;
         middle_ff     <= middle_in;
         bottom_ff     <= bottom_in;
         slope_low_ff  <= slope_low_in;
         slope_high_ff <= slope_high_in;
         ltx_ff        <= ltx_in;
         lty_ff        <= lty_in;
         rtx_ff        <= rtx_in;
         rty_ff        <= rty_in;
         lbx_ff        <= lbx_in;
         rbx_ff        <= rbx_in;
         counts_ff     <= counts_in;
         job0_en_ff    <= job0_en_in;
         job1_en_ff    <= job1_en_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      x2_ff         <= x2_in;
      y2_ff         <= y2_in;
      job0_slot_ff  <= job0_slot_in;
      job0_fresh_ff <= job0_fresh_in;
      job1_slot_ff  <= job1_slot_in;
      job1_fresh_ff <= job1_fresh_in;
      rsp_data_ff   <= rsp_data_in;
   end

   a_slope_done_in_slope: assert property (@(posedge clock) disable iff (reset)
      slope_done |-> (state_ff == ST_SLOPE))
      else $error("slope result arrived outside the slope check state");

   a_avg_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      avg_done |-> (state_ff == ST_AVG_WAIT))
      else $error("average result arrived outside the average wait state");

   a_emit_completes: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && !(rsp_valid_ff && rsp_stall))
      |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("result not loaded when the output register was free");

   a_counts_never_wrap: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((counts_ff[0] >= $past(counts_ff[0])) &&
                (counts_ff[1] >= $past(counts_ff[1])) &&
                (counts_ff[2] >= $past(counts_ff[2]))))
      else $error("averaging count decreased or wrapped");

endmodule

// File: tb/lane_segment_tracker_tb.sv
// ----------------------------------------------------------------------------
// Lane segment tracker testbench
// Drives frame markers and line segments through the block and checks every
// returned polygon against an in-bench tracker model. The tests cover frame
// gating, each corner update rule, register extremes, random frames under
// random stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module lane_segment_tracker_tb;
   import lst_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int IDLE_LIMIT    = 3000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int RANDOM_ITEMS  = 1950;
   localparam int HOLD_CYCLES   = 300;
   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

   localparam logic ACTION_FRAME   = 1'b0;
   localparam logic ACTION_SEGMENT = 1'b1;

   localparam int SLOT_RIGHT_TOP_Y    = 0;
   localparam int SLOT_LEFT_BOTTOM_X  = 1;
   localparam int SLOT_RIGHT_BOTTOM_X = 2;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   lst_req_type               req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   lst_rsp_type               rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // tracker model state
   logic [COORD_BITS-1:0] cfg_middle;
   logic [COORD_BITS-1:0] cfg_bottom;
   logic [SLOPE_BITS-1:0] cfg_slope_low;
   logic [SLOPE_BITS-1:0] cfg_slope_high;
   int unsigned           phase_count;
   bit                    frame_live;
   logic [COORD_BITS-1:0] lt_x, lt_y, rt_x, rt_y, lb_x, rb_x;
   longint unsigned       avg_count [3];

   lst_rsp_type polygon_queue [$];

   int unsigned error_count    = 0;
   int unsigned item_count     = 0;
   int unsigned result_count   = 0;
   int unsigned used_segments  = 0;
   int unsigned write_count    = 0;
   int unsigned setting_count  = 1;
   int unsigned burst_left     = 0;
   bit          offering       = 1'b0;
   int unsigned hold_request   = 0;
   int unsigned quiet_cycles   = 0;
   int          stall_mode     = 0;
   int unsigned stall_mode_left = 0;

   lane_segment_tracker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Tracker model
   // ------------------------------------------------------------------------
   function automatic void model_reset();
      cfg_middle     = MIDDLE_COLUMN_RESET;
      cfg_bottom     = BOTTOM_ROW_RESET;
      cfg_slope_low  = SLOPE_LOW_RESET;
      cfg_slope_high = SLOPE_HIGH_RESET;
      phase_count    = 0;
      frame_live     = 1'b0;
      lt_x = LEFT_TOP_X_RESET;
      lt_y = LEFT_TOP_Y_RESET;
      rt_x = RIGHT_TOP_X_RESET;
      rt_y = RIGHT_TOP_Y_RESET;
      lb_x = LEFT_BOTTOM_X_RESET;
      rb_x = RIGHT_BOTTOM_X_RESET;
      foreach (avg_count[i]) avg_count[i] = 0;
   endfunction

   function automatic logic [COORD_BITS-1:0] blend_corner(input logic [COORD_BITS-1:0] held,
                                                          input logic [COORD_BITS-1:0] fresh,
                                                          input int slot);
      longint unsigned c;
      longint unsigned mean;
      c = avg_count[slot];
      if (c == 0) begin
         mean = fresh;
      end else begin
         mean = (held * c + fresh) / (c + 1);
      end
      // saturate the count, keep weighting by its maximum
      if (c < COUNT_MAX) avg_count[slot] = c + 1;
      return mean[COORD_BITS-1:0];
   endfunction

   function automatic void apply_segment(input logic [COORD_BITS-1:0] x1, y1, x2, y2);
      longint unsigned dx;
      longint unsigned dy;
      longint unsigned scaled;
      if (x1 >= x2) return;
      dx = x2 - x1;
      dy = (y1 > y2) ? y1 - y2 : y2 - y1;
      scaled = dy << Q10_BITS;
      if (scaled <= cfg_slope_low * dx || scaled >= cfg_slope_high * dx) return;
      if (x1 > cfg_middle && x2 > cfg_middle) begin
         used_segments++;
         if (y1 > y2) begin
            rt_x = x2;
            rt_y = y2;
            if (cfg_bottom < y1) rb_x = blend_corner(rb_x, x1, SLOT_RIGHT_BOTTOM_X);
         end else begin
            rt_x = x1;
            rt_y = blend_corner(rt_y, y1, SLOT_RIGHT_TOP_Y);
            if (cfg_bottom < y2) rb_x = blend_corner(rb_x, x2, SLOT_RIGHT_BOTTOM_X);
         end
      end else if (x1 < cfg_middle && x2 < cfg_middle) begin
         used_segments++;
         if (y1 < y2) begin
            lt_x = x1;
            lt_y = y1;
            if (cfg_bottom < y2) lb_x = blend_corner(lb_x, x2, SLOT_LEFT_BOTTOM_X);
         end else begin
            lt_x = x2;
            lt_y = y2;
            if (cfg_bottom < y1) lb_x = blend_corner(lb_x, x1, SLOT_LEFT_BOTTOM_X);
         end
      end
   endfunction

   function automatic lst_rsp_type predict_polygon(input lst_req_type txn);
      lst_rsp_type poly;
      if (txn.action == ACTION_FRAME) begin
         phase_count++;
         if (phase_count >= FRAME_DECIMATION) begin
            phase_count = 0;
            frame_live  = 1'b1;
         end else begin
            frame_live  = 1'b0;
         end
      end else if (frame_live) begin
         apply_segment(txn.start_x, txn.start_y, txn.end_x, txn.end_y);
      end
      poly.left_top_x     = lt_x;
      poly.left_top_y     = lt_y;
      poly.right_top_x    = rt_x;
      poly.right_top_y    = rt_y;
      poly.left_bottom_x  = lb_x;
      poly.left_bottom_y  = cfg_bottom;
      poly.right_bottom_x = rb_x;
      poly.right_bottom_y = cfg_bottom;
      return poly;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH %0d at %0t: %s", error_count, $realtime, what);
   endtask

   task automatic check_corner(input string name, input logic [COORD_BITS-1:0] got,
                               input logic [COORD_BITS-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s = %0d, model %0d", result_count, name,
                                   got, want));
   endtask

   always @(posedge clock) begin
      lst_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (polygon_queue.size() == 0) begin
            report_mismatch($sformatf("polygon with no transaction pending: %h", rsp_data));
         end else begin
            want = polygon_queue.pop_front();
            check_corner("left_top_x", rsp_data.left_top_x, want.left_top_x);
            check_corner("left_top_y", rsp_data.left_top_y, want.left_top_y);
            check_corner("right_top_x", rsp_data.right_top_x, want.right_top_x);
            check_corner("right_top_y", rsp_data.right_top_y, want.right_top_y);
            check_corner("left_bottom_x", rsp_data.left_bottom_x, want.left_bottom_x);
            check_corner("left_bottom_y", rsp_data.left_bottom_y, want.left_bottom_y);
            check_corner("right_bottom_x", rsp_data.right_bottom_x, want.right_bottom_x);
            check_corner("right_bottom_y", rsp_data.right_bottom_y, want.right_bottom_y);
            result_count++;
         end
      end
   end

   // receiver: long hold-off on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request != 0) begin
         rsp_stall    <= 1'b1;
         hold_request <= hold_request - 1;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(20, 200);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("no transaction for %0d cycles, %0d polygons outstanding", quiet_cycles,
                  polygon_queue.size());
         $display("[lane_segment_tracker] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_transaction(input lst_req_type txn);
      req_valid <= 1'b1;
      req_data  <= txn;
      offering   = 1'b1;
      do @(posedge clock); while (req_stall);
      polygon_queue.push_back(predict_polygon(txn));
      item_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         offering   = 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // drop valid, wait for every polygon, then let the block go quiet
   task automatic settle_block(input int unsigned extra);
      if (offering) begin
         req_valid <= 1'b0;
         offering   = 1'b0;
      end
      while (polygon_queue.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_BITS-1:0] middle,
                             input logic [CSR_DATA_BITS-1:0] bottom,
                             input logic [CSR_DATA_BITS-1:0] slope_low,
                             input logic [CSR_DATA_BITS-1:0] slope_high);
      logic [CSR_INDEX_BITS-1:0] idx [4];
      logic [CSR_DATA_BITS-1:0]  val [4];
      idx = '{CSR_MIDDLE_COLUMN, CSR_BOTTOM_ROW, CSR_SLOPE_LOW_Q10, CSR_SLOPE_HIGH_Q10};
      val = '{middle, bottom, slope_low, slope_high};
      settle_block(4);
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_MIDDLE_COLUMN:  cfg_middle     = val[i][COORD_BITS-1:0];
            CSR_BOTTOM_ROW:     cfg_bottom     = val[i][COORD_BITS-1:0];
            CSR_SLOPE_LOW_Q10:  cfg_slope_low  = val[i][SLOPE_BITS-1:0];
            CSR_SLOPE_HIGH_Q10: cfg_slope_high = val[i][SLOPE_BITS-1:0];
            default: ;
         endcase
         write_count++;
      end
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   function automatic lst_req_type segment_at(input int unsigned x1, y1, x2, y2);
      lst_req_type s;
      s.action  = ACTION_SEGMENT;
      s.start_x = x1[COORD_BITS-1:0];
      s.start_y = y1[COORD_BITS-1:0];
      s.end_x   = x2[COORD_BITS-1:0];
      s.end_y   = y2[COORD_BITS-1:0];
      return s;
   endfunction

   function automatic lst_req_type stray_item();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(lst_req_type)-1:0];
   endfunction

   function automatic lst_req_type frame_marker();
      lst_req_type s;
      s = stray_item();
      s.action = ACTION_FRAME;
      return s;
   endfunction

   // a segment aimed inside the slope window on one side of the middle
   function automatic lst_req_type lane_segment();
      int unsigned dx, dy, k, x_lo, y_lo;
      dx = $urandom_range(1, 400);
      if (cfg_slope_high > cfg_slope_low + 1)
         k = $urandom_range(cfg_slope_low + 1, cfg_slope_high - 1);
      else
         k = $urandom_range(0, 4095);
      dy = (k * dx) / 1024 + $urandom_range(0, 1);
      if (dy > 2047) dy = 2047;
      if ($urandom_range(0, 1)) begin
         if (cfg_middle + 1 + dx <= 2047) x_lo = $urandom_range(cfg_middle + 1, 2047 - dx);
         else x_lo = $urandom_range(0, 2047 - dx);
      end else begin
         if (cfg_middle > dx) x_lo = $urandom_range(0, cfg_middle - dx - 1);
         else x_lo = $urandom_range(0, 2047 - dx);
      end
      y_lo = $urandom_range(0, 2047 - dy);
      if ($urandom_range(0, 1))
         return segment_at(x_lo, y_lo, x_lo + dx, y_lo + dy);
      else
         return segment_at(x_lo, y_lo + dy, x_lo + dx, y_lo);
   endfunction

   // one marker, then a handful of mostly well-formed segments
   task automatic run_frames(input int unsigned frames);
      for (int unsigned f = 0; f < frames; f++) begin
         send_transaction(frame_marker());
         repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 9) < 8) send_transaction(lane_segment());
            else send_transaction(stray_item());
         end
      end
   endtask

   task automatic run_until(input int unsigned target);
      while (item_count < target) run_frames(1);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_frame_gating();
      lst_req_type s;
      send_transaction(segment_at(700, 400, 800, 500));
      s = '1;
      s.action = ACTION_FRAME;
      send_transaction(s);
      send_transaction('0);
      send_transaction(segment_at(700, 400, 800, 500));
      send_transaction('0);
      send_transaction(segment_at(700, 400, 800, 500));
   endtask

   task automatic test_corner_updates();
      send_transaction(segment_at(700, 600, 800, 500));
      send_transaction(segment_at(700, 450, 800, 550));
      send_transaction(segment_at(300, 450, 400, 550));
      send_transaction(segment_at(300, 550, 400, 450));
      send_transaction(segment_at(625, 400, 725, 500));
      send_transaction(segment_at(700, 400, 700, 500));
      send_transaction(segment_at(2047, 0, 0, 2047));
      send_transaction(segment_at(700, 500, 800, 500));
      // slope exactly on each bound, then just inside the low one
      send_transaction(segment_at(700, 0, 1724, 591));
      send_transaction(segment_at(700, 0, 1724, 1220));
      send_transaction(segment_at(700, 0, 1724, 592));
      send_transaction(segment_at(0, 2047, 100, 1947));
      send_transaction(segment_at(1947, 0, 2047, 100));
   endtask

   task automatic test_config_extremes();
      set_config(12'd0, 12'd0, 12'd0, 12'd4095);
      run_frames(4);
      // all-ones data: coordinate registers keep their low bits, empty slope range
      set_config(12'd4095, 12'd2047, 12'd4095, 12'd0);
      run_frames(4);
      set_config(12'd1024, 12'd4095, 12'd0, 12'd1);
      run_frames(4);
   endtask

   task automatic test_random_frames(input int unsigned target, input bit fresh_setting);
      int unsigned low;
      if (fresh_setting) begin
         low = $urandom_range(300, 900);
         set_config($urandom_range(300, 1700) | ($urandom_range(0, 1) << 11),
                    $urandom_range(0, 4095), low, $urandom_range(low + 1, 2500));
      end
      run_until(target);
   endtask

   task automatic test_output_backpressure();
      hold_request = HOLD_CYCLES;
      burst_left   = 60;
      run_frames(8);
   endtask

   initial begin
      model_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_frame_gating();
      test_corner_updates();
      test_random_frames(700, 1'b0);
      test_config_extremes();
      test_random_frames(1250, 1'b1);
      test_output_backpressure();
      test_random_frames(RANDOM_ITEMS, 1'b1);

      settle_block(DRAIN_CYCLES);
      if (polygon_queue.size() != 0)
         report_mismatch($sformatf("%0d polygons never returned", polygon_queue.size()));
      $display("%0d transactions, %0d polygons checked, %0d segments moved the lane",
               item_count, result_count, used_segments);
      $display("%0d register writes over %0d settings, incl. extremes and an empty range",
               write_count, setting_count);
      if (error_count == 0)
         $display("[lane_segment_tracker] OK");
      else
         $display("[lane_segment_tracker] ERROR");
      $finish;
   end

endmodule
